@@ rtl/core/bos_pkg.sv @@
`timescale 1ns / 1ps

package bos_pkg;

  localparam int TimeW  = 32;
  localparam int FadeW  = 12;
  localparam int HoldW  = 16;
  localparam int LevelW = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [LevelW-1:0] FullLevel = 8'd255;

  localparam logic [FadeW-1:0] FadeOutReset  = 12'd3000;
  localparam logic [HoldW-1:0] HoldDarkReset = 16'd120;
  localparam logic [FadeW-1:0] FadeInReset   = 12'd3000;
  localparam logic [HoldW-1:0] HoldFullReset = 16'd520;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_FADE_OUT  = 2'd0,
    PH_HOLD_DARK = 2'd1,
    PH_FADE_IN   = 2'd2,
    PH_HOLD_FULL = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_OUT  = 2'd0,
    CFG_HOLD_DARK = 2'd1,
    CFG_FADE_IN   = 2'd2,
    CFG_HOLD_FULL = 2'd3
  } cfg_idx_e;

  // request to the easing unit: drop = floor(x*x*255 / (d*d))
  typedef struct packed {
    logic             start;
    logic [FadeW-1:0] x;
    logic [FadeW-1:0] d;
  } ease_req_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] drop;
  } ease_rsp_t;

endpackage

@@ rtl/core/bos_ease.sv @@
`timescale 1ns / 1ps

module bos_ease import bos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ease_req_t req_i,
  output ease_rsp_t rsp_o
);

  localparam int ProdW = 2 * FadeW;
  localparam int NumW  = ProdW + LevelW;
  localparam int DshW  = ProdW + LevelW - 1;
  localparam int CntW  = $clog2(FadeW);

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL,
    E_PREP,
    E_DIV
  } ease_state_e;

  ease_state_e       state_q;
  logic [CntW-1:0]   cnt_q;
  logic [FadeW-1:0]  xa_q, da_q, mx_q, md_q;
  logic [ProdW-1:0]  pxx_q, pdd_q;
  logic [NumW-1:0]   rem_q;
  logic [DshW-1:0]   dsh_q;
  logic [LevelW-1:0] quo_q;
  logic              done_q;

  logic [ProdW-1:0] pxx_d, pdd_d;
  logic [NumW-1:0]  num_d;
  logic             ge;

  always_comb begin
    // MSB-first shift-add, one multiplier bit per cycle
    pxx_d = {pxx_q[ProdW-2:0], 1'b0} + (mx_q[FadeW-1] ? ProdW'(xa_q) : '0);
    pdd_d = {pdd_q[ProdW-2:0], 1'b0} + (md_q[FadeW-1] ? ProdW'(da_q) : '0);
    // times 255 as times 256 minus one
    num_d = {pxx_q, {LevelW{1'b0}}} - NumW'(pxx_q);
    ge    = rem_q >= NumW'(dsh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (req_i.start) begin
            state_q <= E_MUL;
            cnt_q   <= '0;
          end
        end
        E_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(FadeW - 1)) begin
            state_q <= E_PREP;
          end
        end
        E_PREP: begin
          state_q <= E_DIV;
          cnt_q   <= '0;
        end
        E_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(LevelW - 1)) begin
            state_q <= E_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: begin
        xa_q  <= req_i.x;
        da_q  <= req_i.d;
        mx_q  <= req_i.x;
        md_q  <= req_i.d;
        pxx_q <= '0;
        pdd_q <= '0;
      end
      E_MUL: begin
        pxx_q <= pxx_d;
        pdd_q <= pdd_d;
        mx_q  <= {mx_q[FadeW-2:0], 1'b0};
        md_q  <= {md_q[FadeW-2:0], 1'b0};
      end
      E_PREP: begin
        rem_q <= num_d;
        dsh_q <= {pdd_q, {(LevelW-1){1'b0}}};
        quo_q <= '0;
      end
      E_DIV: begin
        // restoring division, one quotient bit per cycle
        if (ge) begin
          rem_q <= rem_q - NumW'(dsh_q);
        end
        quo_q <= {quo_q[LevelW-2:0], ge};
        dsh_q <= {1'b0, dsh_q[DshW-1:1]};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.drop = quo_q;

endmodule

@@ rtl/core/breathing_opacity_sequencer.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                    Payload
// in       in_valid_i / in_ready_o      action_i, now_ms_i
// out      out_valid_o / out_ready_i    opacity_o, phase_o, visible_o
// cfg      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// Start, stop, hold-phase frames and frames that end a phase go straight to
// S_LOAD; a frame inside a fade first waits in S_EASE for the bit-serial
// multiply and restoring divide in bos_ease.
// One item is in flight at a time; in_ready_o is high only when idle.
// A finished beat waits in the output register without holding up the next
// input; its own result then waits until the output register is free.
// Reset is asynchronous, active low, and restores the default durations.

module breathing_opacity_sequencer import bos_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   opacity_o,
  output logic [1:0]          phase_o,
  output logic                visible_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EASE,
    S_LOAD
  } seq_state_e;

  seq_state_e        state_q;
  logic [FadeW-1:0]  fade_out_q, fade_in_q;
  logic [HoldW-1:0]  hold_dark_q, hold_full_q;
  logic              active_q;
  phase_e            phase_q;
  logic [TimeW-1:0]  start_q;
  logic [LevelW-1:0] level_q;
  logic              out_valid_q;
  logic [LevelW-1:0] opacity_q;
  logic [1:0]        phase_out_q;
  logic              visible_q;

  logic              in_acc;
  logic [TimeW-1:0]  t;
  logic              fo_done, hd_done, fi_done, hf_done;
  ease_req_t         ease_req;
  ease_rsp_t         ease_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    // an earlier timestamp counts as no time gone by
    t       = (now_ms_i >= start_q) ? (now_ms_i - start_q) : '0;
    fo_done = t >= TimeW'(fade_out_q);
    hd_done = t >= TimeW'(hold_dark_q);
    fi_done = t >= TimeW'(fade_in_q);
    hf_done = t >= TimeW'(hold_full_q);

    ease_req.start = in_acc && (action_i == ACT_FRAME) && active_q &&
                     (((phase_q == PH_FADE_OUT) && !fo_done) ||
                      ((phase_q == PH_FADE_IN) && !fi_done));
    ease_req.x     = (phase_q == PH_FADE_IN) ? (fade_in_q - t[FadeW-1:0])
                                             : t[FadeW-1:0];
    ease_req.d     = (phase_q == PH_FADE_IN) ? fade_in_q : fade_out_q;
  end

  bos_ease u_ease (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ease_req),
    .rsp_o  (ease_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_out_q  <= FadeOutReset;
      hold_dark_q <= HoldDarkReset;
      fade_in_q   <= FadeInReset;
      hold_full_q <= HoldFullReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FADE_OUT:  fade_out_q  <= cfg_data_i[FadeW-1:0];
        CFG_HOLD_DARK: hold_dark_q <= cfg_data_i[HoldW-1:0];
        CFG_FADE_IN:   fade_in_q   <= cfg_data_i[FadeW-1:0];
        CFG_HOLD_FULL: hold_full_q <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      phase_q     <= PH_FADE_OUT;
      start_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      opacity_q   <= '0;
      phase_out_q <= '0;
      visible_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_LOAD;
            unique case (action_e'(action_i))
              ACT_START: begin
                level_q  <= FullLevel;
                phase_q  <= PH_FADE_OUT;
                start_q  <= now_ms_i;
                active_q <= 1'b1;
              end
              ACT_STOP: active_q <= 1'b0;
              ACT_FRAME: begin
                if (active_q) begin
                  unique case (phase_q)
                    PH_FADE_OUT: begin
                      if (fo_done) begin
                        level_q <= '0;
                        phase_q <= PH_HOLD_DARK;
                        start_q <= now_ms_i;
                      end else begin
                        state_q <= S_EASE;
                      end
                    end
                    PH_HOLD_DARK: begin
                      level_q <= '0;
                      if (hd_done) begin
                        phase_q <= PH_FADE_IN;
                        start_q <= now_ms_i;
                      end
                    end
                    PH_FADE_IN: begin
                      if (fi_done) begin
                        level_q <= FullLevel;
                        phase_q <= PH_HOLD_FULL;
                        start_q <= now_ms_i;
                      end else begin
                        state_q <= S_EASE;
                      end
                    end
                    PH_HOLD_FULL: begin
                      level_q <= FullLevel;
                      if (hf_done) begin
                        phase_q <= PH_FADE_OUT;
                        start_q <= now_ms_i;
                      end
                    end
                    default: ;
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        S_EASE: begin
          if (ease_rsp.done) begin
            level_q <= FullLevel - ease_rsp.drop;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            opacity_q   <= level_q;
            phase_out_q <= phase_q;
            visible_q   <= active_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign opacity_o   = opacity_q;
  assign phase_o     = phase_out_q;
  assign visible_o   = visible_q;

  a_done_in_ease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ease_rsp.done |-> state_q == S_EASE)
    else $error("easing unit finished outside the ease wait");

  a_ease_fade_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EASE |-> (phase_q == PH_FADE_OUT || phase_q == PH_FADE_IN))
    else $error("ease wait in a hold phase");

  a_ease_nonzero_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ease_req.start |-> ease_req.d != '0)
    else $error("ease launched with zero duration");

  a_dark_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && active_q && phase_q == PH_HOLD_DARK) |-> level_q == '0)
    else $error("dark hold with non-zero opacity");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && active_q && phase_q == PH_HOLD_FULL) |-> level_q == FullLevel)
    else $error("full hold without full opacity");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bos_pkg::*;

  localparam logic [1:0] ActSpare   = 2'd3;
  localparam int         QuietLimit = 4000;
  localparam int         MaxReports = 40;

  typedef struct packed {
    logic              active;
    phase_e            phase;
    logic [TimeW-1:0]  since;
    logic [LevelW-1:0] level;
  } breath_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [TimeW-1:0] now;
  } cmd_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i    = ACT_FRAME;
  logic [TimeW-1:0]    now_ms_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [LevelW-1:0]   opacity_o;
  logic [1:0]          phase_o;
  logic                visible_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_FADE_OUT;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  breathing_opacity_sequencer u_top (.*);

  // durations as the block should hold them
  logic [FadeW-1:0] fade_out_len  = FadeOutReset;
  logic [HoldW-1:0] hold_dark_len = HoldDarkReset;
  logic [FadeW-1:0] fade_in_len   = FadeInReset;
  logic [HoldW-1:0] hold_full_len = HoldFullReset;

  cmd_t    cmd_queue[$];
  breath_t looks_due[$];
  breath_t shown_state = '0;
  breath_t plan_state  = '0;

  logic [TimeW-1:0] cursor = '0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int planned      = 0;
  int cmds_taken   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int reg_writes   = 0;
  int settings     = 0;
  int phase_moves  = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [LevelW-1:0] eased_drop(input logic [TimeW-1:0] x,
                                                   input logic [FadeW-1:0] d);
    logic [63:0] q;
    if (d == '0) return FullLevel;
    q = (64'(x) * 64'(x) * 64'd255) / (64'(d) * 64'(d));
    if (q > 64'(FullLevel)) q = 64'(FullLevel);
    return q[LevelW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] phase_len(input phase_e ph);
    case (ph)
      PH_FADE_OUT:  return TimeW'(fade_out_len);
      PH_HOLD_DARK: return TimeW'(hold_dark_len);
      PH_FADE_IN:   return TimeW'(fade_in_len);
      default:      return TimeW'(hold_full_len);
    endcase
  endfunction

  function automatic breath_t breathe_next(input breath_t s, input logic [1:0] act,
                                           input logic [TimeW-1:0] now);
    breath_t          n;
    logic [TimeW-1:0] t;
    n = s;
    t = (now >= s.since) ? now - s.since : '0;
    case (act)
      ACT_START: begin
        n.level  = FullLevel;
        n.phase  = PH_FADE_OUT;
        n.since  = now;
        n.active = 1'b1;
      end
      ACT_STOP: n.active = 1'b0;
      ACT_FRAME: begin
        if (s.active) begin
          case (s.phase)
            PH_FADE_OUT: begin
              if (t >= TimeW'(fade_out_len)) begin
                n.level = '0;
                n.phase = PH_HOLD_DARK;
                n.since = now;
              end else begin
                n.level = FullLevel - eased_drop(t, fade_out_len);
              end
            end
            PH_HOLD_DARK: begin
              n.level = '0;
              if (t >= TimeW'(hold_dark_len)) begin
                n.phase = PH_FADE_IN;
                n.since = now;
              end
            end
            PH_FADE_IN: begin
              if (t >= TimeW'(fade_in_len)) begin
                n.level = FullLevel;
                n.phase = PH_HOLD_FULL;
                n.since = now;
              end else begin
                n.level = FullLevel - eased_drop(TimeW'(fade_in_len) - t, fade_in_len);
              end
            end
            default: begin
              n.level = FullLevel;
              if (t >= TimeW'(hold_full_len)) begin
                n.phase = PH_FADE_OUT;
                n.since = now;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic push_cmd(input logic [1:0] act, input logic [TimeW-1:0] now);
    cmd_queue.push_back({act, now});
    plan_state = breathe_next(plan_state, act, now);
    if (act != ActSpare) planned++;
  endtask

  task automatic set_pacing(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // wait until every queued command has gone in and every result has come out;
  // look between edges so that the driver's updates have all landed
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_valid_i || looks_due.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FADE_OUT:  fade_out_len  = data[FadeW-1:0];
      CFG_HOLD_DARK: hold_dark_len = data;
      CFG_FADE_IN:   fade_in_len   = data[FadeW-1:0];
      default:       hold_full_len = data;
    endcase
    reg_writes++;
  endtask

  task automatic set_durations(input logic [CfgDataW-1:0] fo, input logic [CfgDataW-1:0] hd,
                               input logic [CfgDataW-1:0] fi, input logic [CfgDataW-1:0] hf);
    write_reg(CFG_FADE_OUT, fo);
    write_reg(CFG_HOLD_DARK, hd);
    write_reg(CFG_FADE_IN, fi);
    write_reg(CFG_HOLD_FULL, hf);
    settings++;
  endtask

  // one breathing session: a start, then mostly advancing frames, with noise mixed in
  task automatic breathe_burst(input int frames, input int unsigned step);
    int unsigned pick;
    cursor = $urandom_range(0, 32'hF000_0000);
    push_cmd(ACT_START, cursor);
    repeat (frames) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        // land just short of, on or just past the end of the phase
        cursor = plan_state.since + phase_len(plan_state.phase) + $urandom_range(0, 2) - 1;
        push_cmd(ACT_FRAME, cursor);
      end else if (pick < 80) begin
        cursor = cursor + $urandom_range(0, step);
        push_cmd(ACT_FRAME, cursor);
      end else if (pick < 85) begin
        push_cmd(ACT_FRAME, cursor - $urandom_range(1, step));
      end else if (pick < 91) begin
        push_cmd(ACT_STOP, cursor);
        if ($urandom_range(0, 99) < 60) begin
          cursor = cursor + $urandom_range(0, step);
          push_cmd(ACT_START, cursor);
        end
      end else if (pick < 95) begin
        push_cmd(ActSpare, $urandom());
      end else begin
        push_cmd(ACT_FRAME, $urandom());
      end
    end
  endtask

  task automatic run_breaths(input int count);
    int          goal;
    int unsigned span;
    span = 32'(fade_out_len);
    if (32'(hold_dark_len) > span) span = 32'(hold_dark_len);
    if (32'(fade_in_len) > span) span = 32'(fade_in_len);
    if (32'(hold_full_len) > span) span = 32'(hold_full_len);
    goal = planned + count;
    while (planned < goal) breathe_burst($urandom_range(3, 24), span / 3 + 1);
    settle();
  endtask

  always @(posedge clk_i) begin : feed
    logic    hold_valid;
    cmd_t    nxt;
    breath_t after;
    if (rst_ni) begin
      hold_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        after = breathe_next(shown_state, action_i, now_ms_i);
        if (after.phase != shown_state.phase) phase_moves++;
        shown_state = after;
        looks_due.push_back(after);
        cmds_taken++;
        hold_valid = 1'b0;
      end
      if (!hold_valid && cmd_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = cmd_queue.pop_front();
        action_i   <= nxt.act;
        now_ms_i   <= nxt.now;
        hold_valid = 1'b1;
      end
      in_valid_i <= hold_valid;
    end
  end

  always @(posedge clk_i) begin : watch_results
    breath_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (looks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected beat, got opacity %0d phase %0d visible %0d",
                     $time, opacity_o, phase_o, visible_o);
        end else begin
          want = looks_due.pop_front();
          if (opacity_o !== want.level || phase_o !== want.phase ||
              visible_o !== want.active) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: expected opacity %0d phase %0d visible %0d, %s %0d %0d %0d",
                       $time, want.level, want.phase, want.active,
                       "got", opacity_o, phase_o, visible_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, QuietLimit, looks_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_pacing(38, 54);

    // reset durations: walk one full cycle and its corners
    push_cmd(ACT_FRAME, 32'd5);
    push_cmd(ActSpare, 32'hFFFF_FFFF);
    push_cmd(ACT_STOP, 32'd0);
    push_cmd(ACT_START, 32'd1000);
    push_cmd(ACT_FRAME, 32'd1000);
    push_cmd(ACT_FRAME, 32'd1001);
    push_cmd(ACT_FRAME, 32'd2500);
    push_cmd(ACT_FRAME, 32'd3999);
    push_cmd(ACT_FRAME, 32'd900);
    push_cmd(ACT_FRAME, 32'd4000);
    push_cmd(ACT_FRAME, 32'd4119);
    push_cmd(ACT_FRAME, 32'd4120);
    push_cmd(ACT_FRAME, 32'd4120);
    push_cmd(ACT_FRAME, 32'd5620);
    push_cmd(ACT_FRAME, 32'd7119);
    push_cmd(ACT_FRAME, 32'd7120);
    push_cmd(ACT_FRAME, 32'd7639);
    push_cmd(ACT_FRAME, 32'd7640);
    push_cmd(ACT_STOP, 32'd8000);
    push_cmd(ACT_FRAME, 32'd9000);
    push_cmd(ACT_START, 32'hFFFF_FFFF);
    push_cmd(ACT_FRAME, 32'd0);
    push_cmd(ACT_FRAME, 32'hFFFF_FFFF);
    settle();

    // zero durations: every frame ends its phase at once
    set_durations(16'd0, 16'd0, 16'd0, 16'd0);
    push_cmd(ACT_START, 32'd50);
    repeat (4) push_cmd(ACT_FRAME, 32'd50);
    push_cmd(ACT_FRAME, 32'd49);
    settle();

    // shortest fades, upper bits of the fade writes are dropped
    set_durations(16'hF001, 16'd0, 16'hA001, 16'd0);
    run_breaths(110);
    set_durations(CfgDataW'($urandom_range(1, 60)), CfgDataW'($urandom_range(0, 80)),
                  CfgDataW'($urandom_range(1, 60)), CfgDataW'($urandom_range(0, 80)));
    run_breaths(130);

    set_pacing(54, 38);
    set_durations(16'hFFFF, 16'hFFFF, 16'd4000, 16'hFFFF);
    run_breaths(110);
    set_durations(CfgDataW'($urandom_range(0, 16'hFFFF)),
                  CfgDataW'($urandom_range(0, 16'hFFFF)),
                  CfgDataW'($urandom_range(0, 16'hFFFF)),
                  CfgDataW'($urandom_range(0, 16'hFFFF)));
    run_breaths(130);

    set_pacing(0, 0);
    set_durations(CfgDataW'(FadeOutReset), HoldDarkReset,
                  CfgDataW'(FadeInReset), HoldFullReset);
    run_breaths(130);
    set_durations(CfgDataW'($urandom_range(100, 4000)), CfgDataW'($urandom_range(0, 2000)),
                  CfgDataW'($urandom_range(100, 4000)), CfgDataW'($urandom_range(0, 2000)));
    run_breaths(130);

    repeat (40) @(posedge clk_i);
    $display("%0d commands over %0d duration settings (%0d register writes), %0d phase changes",
             cmds_taken, settings, reg_writes, phase_moves);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && looks_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
